### rtl/slem_pkg.sv
// Shared constants and helper functions of the serial line editor.
// Used by the top level and the testbench; depends on nothing else.
`timescale 1ns / 1ps

package slem_pkg;

    // Line memory geometry.
    localparam int LINE_DEPTH = 32;
    localparam int ADDR_W     = $clog2(LINE_DEPTH);
    localparam int CUR_W      = $clog2(LINE_DEPTH + 1);

    // Field widths.
    localparam int CHAR_W     = 8;
    localparam int MAX_W      = 6;
    localparam int LEN_W      = 6;
    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;
    localparam int CMP_W      = (CUR_W > MAX_W) ? CUR_W : MAX_W;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CHARS   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LED_INITIAL = 1'd1;

    // Reset values of the configuration.
    localparam logic [MAX_W-1:0] MAX_CHARS_RESET = 6'd20;
    localparam logic             LED_INIT_RESET  = 1'b1;

    // Result kinds and command codes.
    localparam logic KIND_ECHO = 1'b0;
    localparam logic KIND_LINE = 1'b1;

    localparam logic [CMD_W-1:0] CMD_OTHER = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ON    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_OFF   = 2'd2;

    // Characters of interest.
    localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_ESC   = 8'd27;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
    localparam logic [CHAR_W-1:0] CH_LT    = 8'd60;
    localparam logic [CHAR_W-1:0] CH_GT    = 8'd62;
    localparam logic [CHAR_W-1:0] CH_A     = 8'd65;
    localparam logic [CHAR_W-1:0] CH_B     = 8'd66;
    localparam logic [CHAR_W-1:0] CH_C     = 8'd67;
    localparam logic [CHAR_W-1:0] CH_E     = 8'd69;
    localparam logic [CHAR_W-1:0] CH_F     = 8'd70;
    localparam logic [CHAR_W-1:0] CH_N     = 8'd78;
    localparam logic [CHAR_W-1:0] CH_O     = 8'd79;
    localparam logic [CHAR_W-1:0] CH_S     = 8'd83;
    localparam logic [CHAR_W-1:0] CH_T     = 8'd84;

    // Sequencer operations.
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_NONE  = 3'd0;
    localparam logic [OP_W-1:0] OP_ECHO  = 3'd1;
    localparam logic [OP_W-1:0] OP_ENTER = 3'd2;
    localparam logic [OP_W-1:0] OP_BS    = 3'd3;
    localparam logic [OP_W-1:0] OP_TAB   = 3'd4;
    localparam logic [OP_W-1:0] OP_ESC   = 3'd5;

    // Sequencer step counter; Enter reads three entries, then emits.
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] ENTER_EMIT_STEP = 3'd3;

    // Classify a received byte into a sequencer operation.
    function automatic logic [OP_W-1:0] decode_op(input logic [CHAR_W-1:0] c);
        logic [OP_W-1:0] op;
        op = OP_NONE;
        if (!c[CHAR_W-1] && (c >= CH_SPACE)) begin
            op = OP_ECHO;
        end else if (c == CH_CR) begin
            op = OP_ENTER;
        end else if (c == CH_BS) begin
            op = OP_BS;
        end else if (c == CH_TAB) begin
            op = OP_TAB;
        end else if (c == CH_ESC) begin
            op = OP_ESC;
        end
        return op;
    endfunction

    // Index of the final echo step of an operation.
    function automatic logic [STEP_W-1:0] last_step(input logic [OP_W-1:0] op);
        logic [STEP_W-1:0] s;
        case (op)
            OP_BS:   s = 3'd2;
            OP_TAB:  s = 3'd4;
            OP_ESC:  s = 3'd4;
            default: s = 3'd0;
        endcase
        return s;
    endfunction

    // Fixed echo text of the multi-character operations.
    function automatic logic [CHAR_W-1:0] text_char(input logic [OP_W-1:0] op,
                                                    input logic [STEP_W-1:0] step);
        logic [CHAR_W-1:0] ch;
        ch = CH_SPACE;
        case (op)
            OP_BS: begin
                ch = (step == 3'd1) ? CH_SPACE : CH_BS;
            end
            OP_TAB, OP_ESC: begin
                case (step)
                    3'd0:    ch = CH_LT;
                    3'd1:    ch = (op == OP_TAB) ? CH_T : CH_E;
                    3'd2:    ch = (op == OP_TAB) ? CH_A : CH_S;
                    3'd3:    ch = (op == OP_TAB) ? CH_B : CH_C;
                    default: ch = CH_GT;
                endcase
            end
            default: ch = CH_SPACE;
        endcase
        return ch;
    endfunction

endpackage

### rtl/slem_ram.sv
// Simple dual-port line memory: one write port, one read port with a
// registered output that holds while no read is issued. No package needed.
`timescale 1ns / 1ps

module slem_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port with a registered output.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/serial_line_editor_command_match.sv
// Top level of the serial line editor with ON / OFF command match.
// Depends on slem_pkg and on the slem_ram line memory.
`timescale 1ns / 1ps

// Usage:
// The s_ channel carries one received byte per request (s_rx_char). The m_
// channel carries result requests: echo characters (m_kind 0) or one
// line-complete result (m_kind 1) with the matched command and the line
// length; m_last marks the final result of each received byte.
// Configuration is written through cfg_we / cfg_index / cfg_data while the
// block is idle; writing led_initial also loads the LED level at once.
// A byte is first registered in the sequencer, and its results then pass
// through the output register; for Enter the first three line entries are
// read from the line memory one per cycle before the match. One result
// per cycle leaves the output register while the receiver does not stall;
// a printable byte gives one result, backspace three, TAB and ESC five and
// Enter one. Ignored bytes leave the sequencer idle. A new byte is
// accepted in the cycle the last result of the previous one is loaded.
// Reset empties the line, loads max_chars 20 and turns the LED on; the
// line memory itself is not cleared. When the receiver stalls, the output
// register holds its request and the sequencer waits behind it.
module serial_line_editor_command_match
    import slem_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Received characters.
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [CHAR_W-1:0]     s_rx_char,
    // Results.
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_kind,
    output logic [CHAR_W-1:0]     m_echo_char,
    output logic [CMD_W-1:0]      m_command,
    output logic [LEN_W-1:0]      m_line_length,
    output logic                  m_led_state,
    output logic                  m_last,
    // Configuration writes.
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Sequencer and line state.
    logic              busy_reg, busy_next;
    logic [OP_W-1:0]   op_reg, op_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic [CUR_W-1:0]  len_reg, len_next;
    logic              on_ok_reg, on_ok_next;
    logic              off_ok_reg, off_ok_next;
    logic [CUR_W-1:0]  cursor_reg, cursor_next;
    logic [MAX_W-1:0]  max_chars_reg, max_chars_next;
    logic              led_level_reg, led_level_next;

    // Output register.
    logic              m_valid_reg, m_valid_next;
    logic              m_kind_reg, m_kind_next;
    logic [CHAR_W-1:0] m_echo_char_reg, m_echo_char_next;
    logic [CMD_W-1:0]  m_command_reg, m_command_next;
    logic [LEN_W-1:0]  m_line_length_reg, m_line_length_next;
    logic              m_led_state_reg, m_led_state_next;
    logic              m_last_reg, m_last_next;

    // Memory ports.
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [CHAR_W-1:0] ram_rdata;

    // Handshake and control.
    logic              out_load;
    logic              enter_read;
    logic              emit;
    logic              seq_last;
    logic              accept;
    logic [OP_W-1:0]   in_op;
    logic              store_ok;
    logic              off_match;
    logic [CMD_W-1:0]  line_cmd;

    slem_ram #(
        .DATA_W (CHAR_W),
        .DEPTH  (LINE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_rx_char),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Handshake: the sequencer frees itself as its last result is loaded.
    assign out_load   = !m_valid_reg || m_ready;
    assign enter_read = busy_reg && (op_reg == OP_ENTER) && (step_reg != ENTER_EMIT_STEP);
    assign emit       = busy_reg && !enter_read && out_load;
    assign seq_last   = (op_reg == OP_ENTER) || (step_reg == last_step(op_reg));
    assign s_ready    = !busy_reg || (emit && seq_last);
    assign accept     = s_valid && s_ready;
    assign in_op      = decode_op(s_rx_char);

    // A printable byte is stored while the line is below both limits.
    assign store_ok = (CMP_W'(cursor_reg) < CMP_W'(max_chars_reg))
                   && (cursor_reg < CUR_W'(LINE_DEPTH));

    // Memory accesses: writes only at acceptance, reads only during Enter,
    // when no byte is accepted, so the two never meet on one entry.
    assign ram_we    = accept && (in_op == OP_ECHO) && store_ok;
    assign ram_waddr = cursor_reg[ADDR_W-1:0];
    assign ram_re    = enter_read;
    assign ram_raddr = ADDR_W'(step_reg);

    // The third entry is still in the read register while Enter emits.
    assign off_match = off_ok_reg && (ram_rdata == CH_F);
    assign line_cmd  = on_ok_reg ? CMD_ON : (off_match ? CMD_OFF : CMD_OTHER);

    // Sequencer, line state and configuration.
    always_comb begin
        busy_next      = busy_reg;
        op_next        = op_reg;
        step_next      = step_reg;
        char_next      = char_reg;
        len_next       = len_reg;
        on_ok_next     = on_ok_reg;
        off_ok_next    = off_ok_reg;
        cursor_next    = cursor_reg;
        max_chars_next = max_chars_reg;
        led_level_next = led_level_reg;

        if (emit && seq_last) begin
            busy_next = 1'b0;
        end
        if (enter_read || emit) begin
            step_next = step_reg + 3'd1;
        end

        // Match flags narrow as the first three entries come back.
        if (busy_reg && (op_reg == OP_ENTER)) begin
            case (step_reg)
                3'd1: begin
                    on_ok_next  = on_ok_reg && (ram_rdata == CH_O);
                    off_ok_next = off_ok_reg && (ram_rdata == CH_O);
                end
                3'd2: begin
                    on_ok_next  = on_ok_reg && (ram_rdata == CH_N);
                    off_ok_next = off_ok_reg && (ram_rdata == CH_F);
                end
                default: begin
                end
            endcase
        end

        if (emit && (op_reg == OP_ENTER)) begin
            if (line_cmd == CMD_ON) begin
                led_level_next = 1'b1;
            end else if (line_cmd == CMD_OFF) begin
                led_level_next = 1'b0;
            end
        end

        if (accept) begin
            busy_next = (in_op != OP_NONE);
            op_next   = in_op;
            step_next = '0;
            char_next = s_rx_char;
            case (in_op)
                OP_ECHO: begin
                    if (store_ok) begin
                        cursor_next = cursor_reg + CUR_W'(1);
                    end
                end
                OP_ENTER: begin
                    len_next    = cursor_reg;
                    on_ok_next  = (cursor_reg == CUR_W'(2));
                    off_ok_next = (cursor_reg == CUR_W'(3));
                    cursor_next = '0;
                end
                OP_BS: begin
                    if (cursor_reg != '0) begin
                        cursor_next = cursor_reg - CUR_W'(1);
                    end
                end
                OP_ESC: begin
                    cursor_next = '0;
                end
                default: begin
                end
            endcase
        end

        if (cfg_we) begin
            case (cfg_index)
                REG_MAX_CHARS:   max_chars_next = cfg_data[MAX_W-1:0];
                REG_LED_INITIAL: led_level_next = cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Output register loads one result per cycle when free.
    always_comb begin
        m_valid_next       = m_valid_reg;
        m_kind_next        = m_kind_reg;
        m_echo_char_next   = m_echo_char_reg;
        m_command_next     = m_command_reg;
        m_line_length_next = m_line_length_reg;
        m_led_state_next   = m_led_state_reg;
        m_last_next        = m_last_reg;

        if (out_load) begin
            m_valid_next = emit;
        end
        if (emit) begin
            m_last_next = seq_last;
            if (op_reg == OP_ENTER) begin
                m_kind_next        = KIND_LINE;
                m_echo_char_next   = '0;
                m_command_next     = line_cmd;
                m_line_length_next = LEN_W'(len_reg);
                m_led_state_next   = led_level_next;
            end else begin
                m_kind_next        = KIND_ECHO;
                m_echo_char_next   = (op_reg == OP_ECHO) ? char_reg
                                                         : text_char(op_reg, step_reg);
                m_command_next     = CMD_OTHER;
                m_line_length_next = '0;
                m_led_state_next   = led_level_reg;
            end
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            op_reg        <= OP_NONE;
            step_reg      <= '0;
            cursor_reg    <= '0;
            max_chars_reg <= MAX_CHARS_RESET;
            led_level_reg <= LED_INIT_RESET;
            m_valid_reg   <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            op_reg        <= op_next;
            step_reg      <= step_next;
            cursor_reg    <= cursor_next;
            max_chars_reg <= max_chars_next;
            led_level_reg <= led_level_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        char_reg          <= char_next;
        len_reg           <= len_next;
        on_ok_reg         <= on_ok_next;
        off_ok_reg        <= off_ok_next;
        m_kind_reg        <= m_kind_next;
        m_echo_char_reg   <= m_echo_char_next;
        m_command_reg     <= m_command_next;
        m_line_length_reg <= m_line_length_next;
        m_led_state_reg   <= m_led_state_next;
        m_last_reg        <= m_last_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_kind        = m_kind_reg;
    assign m_echo_char   = m_echo_char_reg;
    assign m_command     = m_command_reg;
    assign m_line_length = m_line_length_reg;
    assign m_led_state   = m_led_state_reg;
    assign m_last        = m_last_reg;

    // The cursor never passes the end of the line memory.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cursor_reg <= CUR_W'(LINE_DEPTH))
        else $error("cursor beyond line memory");

    // No byte is taken while Enter is still reading the line.
    assert property (@(posedge aclk) disable iff (!aresetn)
        enter_read |-> !s_ready)
        else $error("request accepted during line read");

    // The line memory is never written while Enter reads it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> !(busy_reg && (op_reg == OP_ENTER) && !emit))
        else $error("line write during line read");

    // Enter empties the line at once.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_rx_char == CH_CR)) |=> (cursor_reg == '0))
        else $error("cursor not cleared by enter");

    // A line-complete result is always the final result of its byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_kind == KIND_LINE)) |-> m_last)
        else $error("line result not marked last");

endmodule

### tb/tb_serial_line_editor_command_match.sv
// Self-checking testbench for the serial line editor with ON / OFF command match.
// Drives received bytes and configuration writes, and predicts every echo and line result.
// Depends on slem_pkg and on the serial_line_editor_command_match top level.
`timescale 1ns / 1ps

module tb_serial_line_editor_command_match;
    import slem_pkg::*;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int SETTLE_CYCLES   = 10;
    localparam int ITEMS_PER_PHASE = 35;
    localparam int PHASES          = 8;
    localparam int MAX_REPORTS     = 10;

    typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_e;

    // One result request as seen on the m_ channel.
    typedef struct packed {
        logic              kind;
        logic [CHAR_W-1:0] echo_char;
        logic [CMD_W-1:0]  command;
        logic [LEN_W-1:0]  line_length;
        logic              led_state;
        logic              last;
    } reply_t;

    // Tracks the editor state and the replies still owed to the terminal.
    class editor_scoreboard;
        reply_t            pending_replies[$];
        reply_t            burst[$];
        logic [CHAR_W-1:0] line_buf[LINE_DEPTH];
        int                cursor;
        int                max_chars;
        logic              led_level;
        int                failures;

        function new();
            cursor    = 0;
            max_chars = MAX_CHARS_RESET;
            led_level = LED_INIT_RESET;
            failures  = 0;
        endfunction

        function void add(logic kind, logic [CHAR_W-1:0] ch, logic [CMD_W-1:0] cmd,
                          logic [LEN_W-1:0] len);
            reply_t r;
            r.kind        = kind;
            r.echo_char   = ch;
            r.command     = cmd;
            r.line_length = len;
            r.led_state   = led_level;
            r.last        = 1'b0;
            burst.push_back(r);
        endfunction

        function void add_text(string s);
            for (int i = 0; i < s.len(); i++) begin
                add(KIND_ECHO, s[i], CMD_OTHER, '0);
            end
        endfunction

        // Works out the replies to one accepted byte and updates the line state.
        function void predict_replies(logic [CHAR_W-1:0] c);
            int               limit;
            logic [CMD_W-1:0] cmd;
            limit = (max_chars < LINE_DEPTH) ? max_chars : LINE_DEPTH;
            burst.delete();
            if (!c[CHAR_W-1] && c >= CH_SPACE) begin
                add(KIND_ECHO, c, CMD_OTHER, '0);
                if (cursor < limit) begin
                    line_buf[cursor] = c;
                    cursor++;
                end
            end else if (c == CH_CR) begin
                cmd = CMD_OTHER;
                if (cursor == 2 && line_buf[0] == CH_O && line_buf[1] == CH_N) begin
                    cmd       = CMD_ON;
                    led_level = 1'b1;
                end else if (cursor == 3 && line_buf[0] == CH_O && line_buf[1] == CH_F
                             && line_buf[2] == CH_F) begin
                    cmd       = CMD_OFF;
                    led_level = 1'b0;
                end
                add(KIND_LINE, '0, cmd, LEN_W'(cursor));
                cursor = 0;
            end else if (c == CH_BS) begin
                add(KIND_ECHO, CH_BS, CMD_OTHER, '0);
                add(KIND_ECHO, CH_SPACE, CMD_OTHER, '0);
                add(KIND_ECHO, CH_BS, CMD_OTHER, '0);
                if (cursor > 0) cursor--;
            end else if (c == CH_TAB) begin
                add_text("<TAB>");
            end else if (c == CH_ESC) begin
                add_text("<ESC>");
                cursor = 0;
            end
            // Ignored bytes leave burst empty.
            if (burst.size() > 0) begin
                burst[burst.size() - 1].last = 1'b1;
                foreach (burst[i]) pending_replies.push_back(burst[i]);
            end
        endfunction

        // Compares one accepted result with the oldest owed reply.
        function void check_reply(reply_t got);
            reply_t want;
            if (pending_replies.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("unexpected result: kind=%0d char=%0d cmd=%0d len=%0d",
                             got.kind, got.echo_char, got.command, got.line_length,
                             " led=%0d last=%0d", got.led_state, got.last);
            end else begin
                want = pending_replies.pop_front();
                if (got.kind !== want.kind || got.echo_char !== want.echo_char ||
                    got.command !== want.command || got.line_length !== want.line_length ||
                    got.led_state !== want.led_state || got.last !== want.last) begin
                    failures++;
                    if (failures <= MAX_REPORTS) begin
                        $display("mismatch: expected kind=%0d char=%0d cmd=%0d len=%0d",
                                 want.kind, want.echo_char, want.command, want.line_length,
                                 " led=%0d last=%0d", want.led_state, want.last);
                        $display("          got      kind=%0d char=%0d cmd=%0d len=%0d",
                                 got.kind, got.echo_char, got.command, got.line_length,
                                 " led=%0d last=%0d", got.led_state, got.last);
                    end
                end
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [CHAR_W-1:0]     s_rx_char;
    logic                  m_valid;
    logic                  m_ready;
    logic                  m_kind;
    logic [CHAR_W-1:0]     m_echo_char;
    logic [CMD_W-1:0]      m_command;
    logic [LEN_W-1:0]      m_line_length;
    logic                  m_led_state;
    logic                  m_last;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    editor_scoreboard sb;
    reply_t           seen;
    rx_mode_e         rx_mode;
    logic [7:0]       rx_pattern;
    logic             hold_off_req;
    int               gap_max;
    int               burst_left;
    int               items_sent;
    int               quiet_cycles = 0;

    serial_line_editor_command_match dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_rx_char     (s_rx_char),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_echo_char   (m_echo_char),
        .m_command     (m_command),
        .m_line_length (m_line_length),
        .m_led_state   (m_led_state),
        .m_last        (m_last),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // 10 ns clock.
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Receiver: stalls by mode, and holds off for a long stretch when asked.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                hold_off_req = 1'b0;
            end
            case (rx_mode)
                RX_ALWAYS: m_ready <= 1'b1;
                RX_RANDOM: m_ready <= ($urandom_range(0, 99) < 65);
                default: begin
                    m_ready <= rx_pattern[0];
                    rx_pattern = {rx_pattern[0], rx_pattern[7:1]};
                end
            endcase
        end
    end

    // Monitor: predicts on each accepted request and checks each result request.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.predict_replies(s_rx_char);
            if (m_valid && m_ready) begin
                seen.kind        = m_kind;
                seen.echo_char   = m_echo_char;
                seen.command     = m_command;
                seen.line_length = m_line_length;
                seen.led_state   = m_led_state;
                seen.last        = m_last;
                sb.check_reply(seen);
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a request.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Offers one byte, inserting a random gap at the start of each burst.
    task automatic send_char(input logic [CHAR_W-1:0] c);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = (gap_max > 0) ? $urandom_range(1, gap_max) : 0;
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid   <= 1'b1;
        s_rx_char <= c;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i]);
    endtask

    task automatic send_line(input string s);
        send_text(s);
        send_char(CH_CR);
    endtask

    // Stops offering and waits until every owed reply has arrived.
    task automatic drain_replies();
        s_valid   <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (sb.pending_replies.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Writes both registers; the LED level follows led_initial at once.
    task automatic configure(input int limit_val, input logic led);
        logic [CFG_DATA_W-1:0] d;
        cfg_we    <= 1'b1;
        cfg_index <= REG_MAX_CHARS;
        cfg_data  <= CFG_DATA_W'(limit_val);
        @(posedge aclk);
        d          = CFG_DATA_W'($urandom);
        d[0]       = led;
        cfg_index <= REG_LED_INITIAL;
        cfg_data  <= d;
        @(posedge aclk);
        cfg_we       <= 1'b0;
        sb.max_chars  = limit_val;
        sb.led_level  = led;
    endtask

    initial begin : main_seq
        string       variants[9];
        int          phase_end;
        int          pick;
        int          n;
        int          cap;
        int          limit_val;
        logic        led;
        logic [CHAR_W-1:0] c;

        variants = '{"ON", "OFF", "ON", "OFF", "on", "OF", "ONN", "OFFX", " ON"};
        sb           = new();
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_rx_char    = '0;
        cfg_we       = 1'b0;
        cfg_index    = REG_MAX_CHARS;
        cfg_data     = '0;
        rx_mode      = RX_RANDOM;
        rx_pattern   = 8'hB5;
        hold_off_req = 1'b0;
        gap_max      = 3;
        burst_left   = 0;
        items_sent   = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: both commands, editing keys, ignored bytes, printable extremes.
        send_line("ON");
        send_line("OFF");
        send_char(CH_BS);
        send_char(CH_TAB);
        send_char(CH_ESC);
        send_char(8'd0);
        send_char(8'd31);
        send_char(8'd128);
        send_char(8'd255);
        send_char(CH_SPACE);
        send_char(8'd127);
        send_char(CH_CR);
        send_text("OFX");
        send_char(CH_BS);
        send_line("F");
        send_text("ON");
        send_char(CH_ESC);
        send_char(CH_CR);

        // Random phases, each under its own register setting and idling style.
        for (int ph = 0; ph < PHASES; ph++) begin
            drain_replies();
            case (ph)
                0: begin limit_val = 1;  led = 1'b0; rx_mode = RX_ALWAYS;  gap_max = 0; end
                1: begin limit_val = 32; led = 1'b1; rx_mode = RX_RANDOM;  gap_max = 4; end
                2: begin limit_val = 0;  led = 1'b1; rx_mode = RX_PATTERN; gap_max = 6; end
                3: begin limit_val = 63; led = 1'b0; rx_mode = RX_RANDOM;  gap_max = 3; end
                4: begin limit_val = 2;  led = 1'b1; rx_mode = RX_PATTERN; gap_max = 2; end
                5: begin limit_val = 3;  led = 1'b0; rx_mode = RX_ALWAYS;  gap_max = 5; end
                default: begin
                    limit_val = $urandom_range(0, 63);
                    led       = 1'($urandom_range(0, 1));
                    rx_mode   = rx_mode_e'($urandom_range(0, 2));
                    gap_max   = $urandom_range(0, 6);
                end
            endcase
            rx_pattern = 8'($urandom) | 8'h01;
            configure(limit_val, led);
            // Long receiver stall while the sender keeps offering bytes.
            if (ph == 3) hold_off_req = 1'b1;
            phase_end = items_sent + ITEMS_PER_PHASE;
            while (items_sent < phase_end) begin
                pick = $urandom_range(0, 99);
                if (pick < 35) begin
                    // A typed line with an occasional backspace.
                    cap = ((sb.max_chars < LINE_DEPTH) ? sb.max_chars : LINE_DEPTH) + 3;
                    n   = $urandom_range(0, cap);
                    for (int i = 0; i < n; i++) begin
                        if ($urandom_range(0, 9) == 0) send_char(CH_BS);
                        else send_char(CHAR_W'($urandom_range(32, 127)));
                    end
                    send_char(CH_CR);
                end else if (pick < 55) begin
                    // Command words, exact or near misses, sometimes after an escape.
                    if ($urandom_range(0, 4) == 0) send_char(CH_ESC);
                    send_line(variants[$urandom_range(0, 8)]);
                end else if (pick < 70) begin
                    case ($urandom_range(0, 2))
                        0:       send_char(CH_BS);
                        1:       send_char(CH_TAB);
                        default: send_char(CH_ESC);
                    endcase
                end else if (pick < 80) begin
                    // Noise the editor must ignore.
                    if ($urandom_range(0, 1) == 1) begin
                        c = CHAR_W'($urandom_range(128, 255));
                    end else begin
                        do c = CHAR_W'($urandom_range(0, 31));
                        while (c == CH_BS || c == CH_TAB || c == CH_CR || c == CH_ESC);
                    end
                    send_char(c);
                end else begin
                    send_char(CHAR_W'($urandom_range(0, 255)));
                end
            end
        end

        drain_replies();
        if (sb.failures == 0 && sb.pending_replies.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### serial_line_editor_command_match.f
rtl/slem_pkg.sv
rtl/slem_ram.sv
rtl/serial_line_editor_command_match.sv
tb/tb_serial_line_editor_command_match.sv
